[sv/xlms_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xlms_pkg
// Shared widths, operation and status codes, and the result record of the
// multi-rail stack core.
// ---------------------------------------------------------------------------
package xlms_pkg;

	// Port field widths
	localparam int MODE_W  = 2;
	localparam int RAIL_W  = 3;
	localparam int LABEL_W = 32;

	// Defaults for the top-level parameters
	localparam int XLMS_RAIL_COUNT = 8;
	localparam int XLMS_POOL_NODES = 1024;
	localparam int XLMS_LABEL_BITS = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH    = 2'd0,
		MODE_POP     = 2'd1,
		MODE_MIGRATE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		status_t            status;
	} res_t;

endpackage

[sv/xlms_engine.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xlms_engine
// Operation sequencer: rail head/tail registers, allocation state, and the
// label and link memories with their read-modify-write passes.
// ---------------------------------------------------------------------------
module xlms_engine import xlms_pkg::*; #(
	parameter int RAIL_COUNT = XLMS_RAIL_COUNT,
	parameter int POOL_NODES = XLMS_POOL_NODES,
	parameter int LABEL_BITS = XLMS_LABEL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic [RAIL_W-1:0]         rail,
	input  logic [RAIL_W-1:0]         target_rail,
	input  logic signed [LABEL_W-1:0] item_label,
	output logic                      res_valid,
	output res_t                      res,
	input  logic                      res_ready
);

	localparam int IDX_W   = $clog2(POOL_NODES);
	localparam int FRESH_W = $clog2(POOL_NODES + 1);
	localparam int RAIL_IW = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_WB   = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]   head_q [RAIL_COUNT];
	logic [IDX_W-1:0]   tail_q [RAIL_COUNT];
	logic [FRESH_W-1:0] fresh_q;
	logic [IDX_W-1:0]   free_head_q;

	// Latched operation
	mode_t               op_q;
	logic [RAIL_IW-1:0]  rail_q;
	logic [RAIL_IW-1:0]  tgt_q;
	logic [IDX_W-1:0]    h_q;
	logic [IDX_W-1:0]    ta_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    nxt_q;
	logic [IDX_W-1:0]    bh_q;
	logic                from_free_q;
	logic [LABEL_BITS-1:0] lab_q;
	res_t                res_q;

	// Memories
	logic [LABEL_BITS-1:0] label_mem [POOL_NODES];
	logic [IDX_W-1:0]      link_mem  [POOL_NODES];
	logic [LABEL_BITS-1:0] label_rd;
	logic [IDX_W-1:0]      link_rd;

	logic                  link_re;
	logic [IDX_W-1:0]      link_ra;
	logic                  link_we;
	logic [IDX_W-1:0]      link_wa;
	logic [IDX_W-1:0]      link_wd;
	logic                  label_we;

	logic [RAIL_IW-1:0] rd_rail;
	logic [RAIL_IW-1:0] rail_idx;
	logic [IDX_W-1:0]   head_rd;
	logic [IDX_W-1:0]   tail_rd;
	logic [IDX_W-1:0]   link_d0;
	logic [IDX_W-1:0]   n_new;
	mode_t              mode_in;
	logic               accept;
	logic               rail_ok;
	logic               tgt_ok;
	logic               from_free;
	logic               from_fresh;
	logic               push_go;
	logic               push_full;
	logic               pop_go;
	logic               pop_empty;
	logic               mig_go;
	logic               work;

	assign mode_in  = mode_t'(mode);
	assign accept   = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign rail_idx = RAIL_IW'(rail);

	// One rail read per cycle: source rail at accept, target rail afterwards
	assign rd_rail = (state_q == S_IDLE) ? rail_idx : tgt_q;
	assign head_rd = head_q[rd_rail];
	assign tail_rd = tail_q[rd_rail];

	assign rail_ok = (int'(rail) < RAIL_COUNT);
	assign tgt_ok  = (int'(target_rail) < RAIL_COUNT);

	assign from_free  = (free_head_q != '0);
	assign from_fresh = !from_free && (fresh_q < FRESH_W'(POOL_NODES));
	assign n_new      = from_free ? free_head_q : fresh_q[IDX_W-1:0];

	assign push_go   = (mode_in == MODE_PUSH) && rail_ok && (from_free || from_fresh);
	assign push_full = (mode_in == MODE_PUSH) && rail_ok && !(from_free || from_fresh);
	assign pop_go    = (mode_in == MODE_POP) && rail_ok && (head_rd != '0);
	assign pop_empty = (mode_in == MODE_POP) && rail_ok && (head_rd == '0);
	assign mig_go    = (mode_in == MODE_MIGRATE) && rail_ok && tgt_ok &&
	                   (rail != target_rail) && (head_rd != '0);
	assign work      = push_go || pop_go || mig_go;

	// Treat an out-of-pool link as null
	assign link_d0 = (int'(link_rd) < POOL_NODES) ? link_rd : '0;

	// Link memory port control
	always_comb begin
		link_re  = 1'b0;
		link_ra  = head_rd;
		link_we  = 1'b0;
		link_wa  = n_q;
		link_wd  = h_q;
		label_we = 1'b0;
		if (state_q == S_IDLE) begin
			link_re = accept && work;
			link_ra = (mode_in == MODE_PUSH) ? free_head_q : head_rd;
		end else if (state_q == S_RD) begin
			link_re = 1'b1;
			case (op_q)
				MODE_PUSH: begin
					link_ra  = h_q;
					link_we  = 1'b1;
					link_wa  = n_q;
					link_wd  = h_q;
					label_we = 1'b1;
				end
				MODE_POP: begin
					link_ra = link_d0;
					link_we = 1'b1;
					link_wa = h_q;
					link_wd = free_head_q;
				end
				MODE_MIGRATE: begin
					link_ra = head_rd;
					link_we = (head_rd != '0);
					link_wa = h_q;
					link_wd = link_rd ^ head_rd;
				end
				default: begin
					link_re = 1'b0;
				end
			endcase
		end else if (state_q == S_WB) begin
			case (op_q)
				MODE_PUSH: begin
					link_we = (h_q != '0);
					link_wa = h_q;
					link_wd = link_rd ^ n_q;
				end
				MODE_POP: begin
					link_we = (nxt_q != '0);
					link_wa = nxt_q;
					link_wd = link_rd ^ h_q;
				end
				MODE_MIGRATE: begin
					link_we = (bh_q != '0);
					link_wa = bh_q;
					link_wd = link_rd ^ h_q;
				end
				default: begin
					link_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (link_re) begin
			link_rd <= link_mem[link_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (label_we) begin
			label_mem[n_q] <= lab_q;
		end
		if (accept && pop_go) begin
			label_rd <= label_mem[head_rd];
		end
	end

	// Payload latches
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= mode_in;
			rail_q      <= rail_idx;
			tgt_q       <= RAIL_IW'(target_rail);
			h_q         <= head_rd;
			ta_q        <= tail_rd;
			n_q         <= n_new;
			from_free_q <= from_free;
			lab_q       <= LABEL_BITS'(item_label);
			res_q.label <= '0;
			if (push_full) begin
				res_q.status <= ST_FULL;
			end else if (pop_empty) begin
				res_q.status <= ST_EMPTY;
			end else begin
				res_q.status <= ST_OK;
			end
		end
		if (state_q == S_RD) begin
			nxt_q <= link_d0;
			bh_q  <= head_rd;
			if (op_q == MODE_POP) begin
				res_q.label <= LABEL_W'(label_rd);
			end
		end
	end

	// Rail and allocation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RAIL_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			fresh_q     <= FRESH_W'(1);
			free_head_q <= '0;
		end else begin
			if (accept && push_go) begin
				head_q[rail_idx] <= n_new;
				if (head_rd == '0) begin
					tail_q[rail_idx] <= n_new;
				end
				if (!from_free) begin
					fresh_q <= fresh_q + FRESH_W'(1);
				end
			end
			if (state_q == S_RD) begin
				case (op_q)
					MODE_PUSH: begin
						if (from_free_q) begin
							free_head_q <= link_d0;
						end
					end
					MODE_POP: begin
						head_q[rail_q] <= link_d0;
						if (link_d0 == '0) begin
							tail_q[rail_q] <= '0;
						end
						free_head_q <= h_q;
					end
					MODE_MIGRATE: begin
						head_q[rail_q] <= '0;
						tail_q[rail_q] <= '0;
						head_q[tgt_q]  <= ta_q;
						if (head_rd == '0) begin
							tail_q[tgt_q] <= h_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= work ? S_RD : S_FIN;
					end
				end
				S_RD: begin
					state_q <= S_WB;
				end
				S_WB: begin
					state_q <= res_ready ? S_IDLE : S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = (state_q == S_WB) || (state_q == S_FIN);
	assign res       = res_q;

endmodule

[sv/xlms_out_reg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xlms_out_reg
// Result holding register between the sequencer and the response channel.
// ---------------------------------------------------------------------------
module xlms_out_reg import xlms_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      res_valid,
	input  res_t                      res,
	output logic                      res_ready,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic signed [LABEL_W-1:0] popped_label,
	output logic [1:0]                status
);

	logic valid_q;
	res_t data_q;

	assign res_ready = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	// Load only into a free or draining slot; hold while stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

	assign rsp_valid    = valid_q;
	assign popped_label = signed'(data_q.label);
	assign status       = data_q.status;

endmodule

[sv/xor_linked_multi_stack_core.sv]
`timescale 1ns / 1ps
// Path: push, pop and a moving migrate go through S_RD and S_WB, then the output
//   register behind rsp_valid; a flagged or no-op request takes S_FIN instead.
// Issue: one request at a time, taken only in S_IDLE; a push, pop or moving migrate
//   first makes its read, then write-back, pass over the one-write-port link memory.
// Reset: all rails empty, free list empty, next fresh node is 1; the node
//   memories are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// xor_linked_multi_stack_core
// Several stacks (rails) over one shared node pool. Each node holds a label
// and one XOR link word of its two neighbours; node 0 is null.
// ---------------------------------------------------------------------------
module xor_linked_multi_stack_core import xlms_pkg::*; #(
	parameter int RAIL_COUNT = XLMS_RAIL_COUNT,
	parameter int POOL_NODES = XLMS_POOL_NODES,
	parameter int LABEL_BITS = XLMS_LABEL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Request channel
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic [RAIL_W-1:0]         rail,
	input  logic [RAIL_W-1:0]         target_rail,
	input  logic signed [LABEL_W-1:0] item_label,
	// Response channel
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic signed [LABEL_W-1:0] popped_label,
	output logic [1:0]                status
);

	// Finished result handed from the sequencer to the output register
	logic res_valid;
	logic res_ready;
	res_t res;

	// The sequencer takes one transaction at a time. A push pops the free list
	// (or takes the next fresh node), writes the new node and folds the new
	// index into the old head's link. A pop reads the head, moves the rail to
	// the neighbour, chains the old head onto the free list and folds the old
	// index out of the neighbour's link. A migrate cross-links the two heads, so
	// the source rail's tail becomes the target's new head.
	xlms_engine #(
		.RAIL_COUNT (RAIL_COUNT),
		.POOL_NODES (POOL_NODES),
		.LABEL_BITS (LABEL_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.rail        (rail),
		.target_rail (target_rail),
		.item_label  (item_label),
		.res_valid   (res_valid),
		.res         (res),
		.res_ready   (res_ready)
	);

	// The output register lets the next transaction start while a finished
	// result still waits on a stalled response channel.
	xlms_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.res_ready    (res_ready),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.popped_label (popped_label),
		.status       (status)
	);

endmodule

[sv/xlms_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xlms_checker
// Port-level checks on the multi-rail stack core, bound to the top level.
// ---------------------------------------------------------------------------
module xlms_checker import xlms_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      req_valid,
	input logic                      req_stall,
	input logic                      rsp_valid,
	input logic                      rsp_stall,
	input logic signed [LABEL_W-1:0] popped_label,
	input logic [1:0]                status
);

	// A held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(popped_label) && $stable(status))
		else $error("response changed while stalled");

	// Only the three defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
		else $error("undefined status code");

	// A flagged result carries no label
	a_flag_label: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> popped_label == '0)
		else $error("flagged result with nonzero label");

	// One request at a time: the cycle after a transaction is taken stalls
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

endmodule

bind xor_linked_multi_stack_core xlms_checker u_xlms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.popped_label (popped_label),
	.status       (status)
);

[test/xor_linked_multi_stack_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_linked_multi_stack_checker
// Watches both channels of the multi-rail stack core, predicts the result of
// every accepted request and compares each accepted response against it.
// ---------------------------------------------------------------------------
module xor_linked_multi_stack_checker import xlms_pkg::*; #(
	parameter int RAIL_COUNT = XLMS_RAIL_COUNT,
	parameter int POOL_NODES = XLMS_POOL_NODES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  logic [MODE_W-1:0]         mode,
	input  logic [RAIL_W-1:0]         rail,
	input  logic [RAIL_W-1:0]         target_rail,
	input  logic signed [LABEL_W-1:0] item_label,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  logic signed [LABEL_W-1:0] popped_label,
	input  logic [1:0]                status,
	output int                        fail_count,
	output int                        pending_count
);

	localparam int IDX_W = $clog2(POOL_NODES);

	// Shadow of the node pool and rail bookkeeping
	logic [LABEL_W-1:0] node_label [POOL_NODES];
	logic [IDX_W-1:0]   node_link  [POOL_NODES];
	logic [IDX_W-1:0]   rail_head  [RAIL_COUNT];
	logic [IDX_W-1:0]   rail_tail  [RAIL_COUNT];
	logic [IDX_W:0]     fresh_node;
	logic [IDX_W-1:0]   free_top;

	res_t awaited_results [$];
	int   mismatches;

	function automatic res_t predict_op(logic [MODE_W-1:0] op, logic [RAIL_W-1:0] r,
			logic [RAIL_W-1:0] t, logic [LABEL_W-1:0] lab);
		res_t             res;
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] nxt;
		logic [IDX_W-1:0] src_head;
		logic [IDX_W-1:0] dst_head;
		res.label  = '0;
		res.status = ST_OK;
		case (op)
			MODE_PUSH: begin
				if (int'(r) < RAIL_COUNT) begin
					if (free_top != 0) begin
						n        = free_top;
						free_top = node_link[n];
					end else if (int'(fresh_node) < POOL_NODES) begin
						n          = fresh_node[IDX_W-1:0];
						fresh_node = fresh_node + 1'b1;
					end else begin
						res.status = ST_FULL;
						return res;
					end
					node_label[n] = lab;
					node_link[n]  = rail_head[r];
					if (rail_head[r] != 0)
						node_link[rail_head[r]] ^= n;
					else
						rail_tail[r] = n;
					rail_head[r] = n;
				end
			end
			MODE_POP: begin
				if (int'(r) < RAIL_COUNT) begin
					n = rail_head[r];
					if (n == 0) begin
						res.status = ST_EMPTY;
						return res;
					end
					res.label    = node_label[n];
					nxt          = node_link[n];
					rail_head[r] = nxt;
					if (nxt != 0)
						node_link[nxt] ^= n;
					else
						rail_tail[r] = '0;
					node_link[n] = free_top;
					free_top     = n;
				end
			end
			MODE_MIGRATE: begin
				if (int'(r) < RAIL_COUNT && int'(t) < RAIL_COUNT) begin
					src_head = rail_head[r];
					dst_head = rail_head[t];
					if (r != t && src_head != 0) begin
						// join the two heads; the source tail becomes the new head
						if (dst_head != 0) begin
							node_link[dst_head] ^= src_head;
							node_link[src_head] ^= dst_head;
						end else begin
							rail_tail[t] = src_head;
						end
						rail_head[t] = rail_tail[r];
						rail_head[r] = '0;
						rail_tail[r] = '0;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] checker: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			for (int k = 0; k < RAIL_COUNT; k++) begin
				rail_head[k] = '0;
				rail_tail[k] = '0;
			end
			fresh_node = (IDX_W + 1)'(1);
			free_top   = '0;
			awaited_results.delete();
			mismatches    = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					want = awaited_results.pop_front();
					if (popped_label !== want.label)
						report_mismatch($sformatf("popped_label %h, want %h",
							popped_label, want.label));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							status, want.status));
				end
			end
			if (req_valid && !req_stall)
				awaited_results.push_back(predict_op(mode, rail, target_rail, item_label));
			fail_count    <= mismatches;
			pending_count <= awaited_results.size();
		end
	end

endmodule

[test/xor_linked_multi_stack_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_linked_multi_stack_core_tb
// Drives directed and random push, pop and migrate transactions into the
// multi-rail stack core with random gaps and stalls; a checker beside the
// core predicts and compares every response.
// ---------------------------------------------------------------------------
module xor_linked_multi_stack_core_tb;
	import xlms_pkg::*;

	localparam int RAIL_COUNT = XLMS_RAIL_COUNT;
	localparam int POOL_NODES = XLMS_POOL_NODES;

	// the fourth mode code is unused by the core and must be a no-op
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	// enough pushes in the fill phase to run the pool dry with room to spare
	localparam int FILL_PUSHES = POOL_NODES + 8;

	logic                      clk;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_stall;
	logic [MODE_W-1:0]         mode;
	logic [RAIL_W-1:0]         rail;
	logic [RAIL_W-1:0]         target_rail;
	logic signed [LABEL_W-1:0] item_label;
	logic                      rsp_valid;
	logic                      rsp_stall;
	logic signed [LABEL_W-1:0] popped_label;
	logic [1:0]                status;

	int fail_count;
	int pending_count;

	int  sent_count;
	int  pushes_sent;
	bit  send_steady;
	int  taken_count;
	bit  take_steady;

	xor_linked_multi_stack_core #(
		.RAIL_COUNT(RAIL_COUNT),
		.POOL_NODES(POOL_NODES),
		.LABEL_BITS(XLMS_LABEL_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.rail        (rail),
		.target_rail (target_rail),
		.item_label  (item_label),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.popped_label(popped_label),
		.status      (status)
	);

	xor_linked_multi_stack_checker #(
		.RAIL_COUNT(RAIL_COUNT),
		.POOL_NODES(POOL_NODES)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.rail         (rail),
		.target_rail  (target_rail),
		.item_label   (item_label),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.popped_label (popped_label),
		.status       (status),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: end the run with an error if it never finishes
	initial begin
		#6_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Send one request transaction: idle for a random gap, then hold the
	// payload with valid high until the core takes it.
	task automatic send_request(logic [MODE_W-1:0] op, logic [RAIL_W-1:0] r,
			logic [RAIL_W-1:0] t, logic [LABEL_W-1:0] lab);
		int gap;
		// re-draw every 40 transactions whether this stretch runs back to back
		if (sent_count % 40 == 0)
			send_steady = ($urandom_range(3) == 0);
		gap = send_steady ? 0 : $urandom_range(15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode        <= op;
		rail        <= r;
		target_rail <= t;
		item_label  <= lab;
		req_valid   <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent_count++;
		if (op == MODE_PUSH)
			pushes_sent++;
	endtask

	// Pick one random transaction; weights are percentages, the rest of the
	// hundred goes to the spare code.
	task automatic random_request(int push_pct, int pop_pct, int migrate_pct);
		int               pick;
		logic [MODE_W-1:0] op;
		pick = $urandom_range(99);
		if (pick < push_pct)
			op = MODE_PUSH;
		else if (pick < push_pct + pop_pct)
			op = MODE_POP;
		else if (pick < push_pct + pop_pct + migrate_pct)
			op = MODE_MIGRATE;
		else
			op = MODE_SPARE;
		send_request(op, RAIL_W'($urandom_range(RAIL_COUNT - 1)),
			RAIL_W'($urandom_range(RAIL_COUNT - 1)), LABEL_W'($urandom));
	endtask

	// Response side: stall for a random count, then accept the next result
	initial begin
		int hold;
		rsp_stall   = 1'b1;
		taken_count = 0;
		take_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken_count % 40 == 0)
				take_steady = ($urandom_range(3) == 0);
			hold = take_steady ? 0 : $urandom_range(15);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!(rsp_valid && !rsp_stall)) @(posedge clk);
			taken_count++;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		mode        = MODE_PUSH;
		rail        = '0;
		target_rail = '0;
		item_label  = '0;
		sent_count  = 0;
		pushes_sent = 0;
		send_steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, empty migrate, label extremes, migrate onto
		// itself, onto a filled rail and onto an empty one, the spare code,
		// and reuse of freed nodes.
		send_request(MODE_POP,     3'd0, 3'd0, 32'h0);
		send_request(MODE_MIGRATE, 3'd1, 3'd2, 32'h0);
		send_request(MODE_PUSH,    3'd0, 3'd7, 32'h7FFF_FFFF);
		send_request(MODE_PUSH,    3'd0, 3'd0, 32'h8000_0000);
		send_request(MODE_PUSH,    3'd0, 3'd0, 32'h0000_0000);
		send_request(MODE_PUSH,    3'd0, 3'd0, 32'hFFFF_FFFF);
		send_request(MODE_PUSH,    3'd7, 3'd0, 32'h0000_0001);
		send_request(MODE_PUSH,    3'd7, 3'd0, 32'h0000_0002);
		send_request(MODE_MIGRATE, 3'd0, 3'd0, 32'h0);
		send_request(MODE_MIGRATE, 3'd0, 3'd7, 32'h0);
		send_request(MODE_MIGRATE, 3'd7, 3'd3, 32'h0);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);
		send_request(MODE_SPARE,   3'd7, 3'd7, 32'hFFFF_FFFF);
		send_request(MODE_PUSH,    3'd5, 3'd0, 32'h1234_5678);
		send_request(MODE_PUSH,    3'd5, 3'd0, 32'hDEAD_BEEF);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);
		send_request(MODE_POP,     3'd3, 3'd0, 32'h0);

		// Mixed traffic with many empty pops
		repeat (60) random_request(45, 40, 12);

		// Fill the pool without popping until pushes are refused as full
		pushes_sent = 0;
		while (pushes_sent < FILL_PUSHES)
			random_request(98, 0, 2);

		// Drain mostly, re-pushing through the free list
		repeat (120) random_request(30, 62, 6);

		// Hold off until the checker has seen every response, then let the
		// pipeline settle so a stray response would still be caught.
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
